>>> hdl/csb_pkg.sv
package csb_pkg;

    // Fixed field widths of the request and response words
    localparam int REQ_W   = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 5;
    localparam int ERR_W   = 2;

    // Request codes; the two unused codes are served as status
    typedef enum logic [REQ_W-1:0] {
        REQ_START   = 3'd0,
        REQ_ADVANCE = 3'd1,
        REQ_INSERT  = 3'd2,
        REQ_ATTACH  = 3'd3,
        REQ_REMOVE  = 3'd4,
        REQ_STATUS  = 3'd5
    } t_req_e;

    // Response error codes
    typedef enum logic [ERR_W-1:0] {
        ERR_OK         = 2'd0,
        ERR_NO_CURRENT = 2'd1,
        ERR_FULL       = 2'd2
    } t_err_e;

    // Command broadcast to every cell of the row
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2
    } t_cell_mode_e;

endpackage

>>> hdl/csb_if.sv
// Request channel: one word per request
interface csb_req_if
    import csb_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [VALUE_W-1:0] new_value;

    modport source (output valid, output req_type, output new_value, input ready);
    modport sink   (input valid, input req_type, input new_value, output ready);
endinterface

// Response channel: one word per request
interface csb_rsp_if
    import csb_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] current_value;
    logic               has_current;
    logic [POS_W-1:0]   entry_count;
    logic [POS_W-1:0]   cursor_pos;
    logic [ERR_W-1:0]   error_code;

    modport source (output valid, output current_value, output has_current,
                    output entry_count, output cursor_pos, output error_code,
                    input ready);
    modport sink   (input valid, input current_value, input has_current,
                    input entry_count, input cursor_pos, input error_code,
                    output ready);
endinterface

>>> hdl/csb_cell.sv
// One storage slot of the row; takes its left or right neighbor on a shift
module csb_cell
    import csb_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int IDX_W      = 4
) (
    input  logic                  i_clk,
    input  t_cell_mode_e          i_mode,
    input  logic [IDX_W-1:0]      i_pos,
    input  logic [IDX_W-1:0]      i_index,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_data
);

    logic [DATA_WIDTH-1:0] r_data;

    // insert: load at the gap, move up above it; remove: move down from it
    always_ff @(posedge i_clk) begin
        unique case (i_mode)
            CELL_INS: begin
                if (i_index == i_pos) begin
                    r_data <= i_value;
                end else if (i_index > i_pos) begin
                    r_data <= i_left;
                end
            end
            CELL_DEL: begin
                if (i_index >= i_pos) begin
                    r_data <= i_right;
                end
            end
            default: begin
                r_data <= r_data;
            end
        endcase
    end

    assign o_data = r_data;

endmodule

>>> hdl/cursor_sequence_buffer_top.sv
// Ordered buffer of up to DEPTH values with a cursor.
// i_req carries one request word (req_type, new_value); o_rsp returns one
// response word per request: the entry under the cursor after the step, a
// has-current flag, the entry count, the cursor position and an error code.
// Codes: 0 start, 1 advance, 2 insert before, 3 attach after, 4 remove,
// 5 status (6 and 7 act as status). Errors leave the state unchanged.
// Storage is a row of DEPTH cells; on insert the cell at the insert position
// loads the value and every cell above it shifts up by one slot, and on remove
// every cell at or past the cursor shifts down by one, all in the same cycle.
// The response is registered and valid in the cycle after the request is
// accepted. One request is taken per cycle while the response side keeps up.
// A stalled response holds in the output register; a new request is taken
// only when that register is empty or being drained in the same cycle.
// Reset (synchronous, active low) empties the buffer and puts the cursor at
// zero; the entries themselves are not cleared and no clearing pass runs.
module cursor_sequence_buffer_top
    import csb_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    csb_req_if.sink    i_req,
    csb_rsp_if.source  o_rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_cursor;
    logic                  r_out_valid;
    logic [VALUE_W-1:0]    r_out_value;
    logic                  r_out_has;
    logic [POS_W-1:0]      r_out_count;
    logic [POS_W-1:0]      r_out_cursor;
    t_err_e                r_out_err;

    logic [CNT_W-1:0]      n_count;
    logic [CNT_W-1:0]      n_cursor;
    t_err_e                n_err;
    t_cell_mode_e          n_mode;
    logic [IDX_W-1:0]      n_pos;
    logic [CNT_W-1:0]      rd_idx;
    logic                  use_new;
    logic                  n_has;
    logic [DATA_WIDTH-1:0] n_value;

    logic                  accept;
    logic                  cur_valid;
    logic                  full;
    logic [DATA_WIDTH-1:0] in_value;
    t_cell_mode_e          cell_mode;
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];

    assign accept    = i_req.valid && i_req.ready;
    // no request is taken while reset is held
    assign i_req.ready = i_rst_n && (!r_out_valid || o_rsp.ready);
    assign cur_valid = r_cursor < r_count;
    assign full      = r_count == CNT_W'(DEPTH);
    assign in_value  = DATA_WIDTH'(i_req.new_value);
    assign cell_mode = accept ? n_mode : CELL_HOLD;

    // Request decode: next count and cursor, cell command, read select
    always_comb begin
        n_count  = r_count;
        n_cursor = r_cursor;
        n_err    = ERR_OK;
        n_mode   = CELL_HOLD;
        n_pos    = '0;
        rd_idx   = r_cursor;
        use_new  = 1'b0;
        unique case (t_req_e'(i_req.req_type))
            REQ_START: begin
                n_cursor = '0;
                rd_idx   = '0;
            end
            REQ_ADVANCE: begin
                if (!cur_valid) begin
                    n_err = ERR_NO_CURRENT;
                end else begin
                    n_cursor = CNT_W'(r_cursor + 1'b1);
                    rd_idx   = CNT_W'(r_cursor + 1'b1);
                end
            end
            REQ_INSERT: begin
                if (full) begin
                    n_err = ERR_FULL;
                end else begin
                    n_pos    = cur_valid ? IDX_W'(r_cursor) : '0;
                    n_cursor = cur_valid ? r_cursor : '0;
                    n_count  = CNT_W'(r_count + 1'b1);
                    n_mode   = CELL_INS;
                    use_new  = 1'b1;
                end
            end
            REQ_ATTACH: begin
                if (full) begin
                    n_err = ERR_FULL;
                end else begin
                    n_cursor = cur_valid ? CNT_W'(r_cursor + 1'b1) : r_count;
                    n_pos    = cur_valid ? IDX_W'(r_cursor + 1'b1) : IDX_W'(r_count);
                    n_count  = CNT_W'(r_count + 1'b1);
                    n_mode   = CELL_INS;
                    use_new  = 1'b1;
                end
            end
            REQ_REMOVE: begin
                if (!cur_valid) begin
                    n_err = ERR_NO_CURRENT;
                end else begin
                    n_pos   = IDX_W'(r_cursor);
                    n_count = CNT_W'(r_count - 1'b1);
                    n_mode  = CELL_DEL;
                    rd_idx  = CNT_W'(r_cursor + 1'b1);
                end
            end
            default: begin
                n_err = ERR_OK;
            end
        endcase
    end

    // Entry under the cursor after the step
    assign n_has   = n_cursor < n_count;
    assign n_value = !n_has  ? '0 :
                     use_new ? in_value : cell_data[rd_idx[IDX_W-1:0]];

    // Row of storage cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] left;
        logic [DATA_WIDTH-1:0] right;
        if (g == 0) begin : g_first
            assign left = in_value;
        end else begin : g_mid
            assign left = cell_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right = cell_data[g];
        end else begin : g_inner
            assign right = cell_data[g+1];
        end
        csb_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IDX_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_mode  (cell_mode),
            .i_pos   (n_pos),
            .i_index (IDX_W'(g)),
            .i_value (in_value),
            .i_left  (left),
            .i_right (right),
            .o_data  (cell_data[g])
        );
    end

    // Control state and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_cursor    <= n_cursor;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_out_value  <= VALUE_W'(n_value);
            r_out_has    <= n_has;
            r_out_count  <= POS_W'(n_count);
            r_out_cursor <= POS_W'(n_cursor);
            r_out_err    <= n_err;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.current_value = r_out_value;
    assign o_rsp.has_current   = r_out_has;
    assign o_rsp.entry_count   = r_out_count;
    assign o_rsp.cursor_pos    = r_out_cursor;
    assign o_rsp.error_code    = r_out_err;

`ifndef SYNTHESIS
    // cursor stays within the stored entries or one past them
    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= r_count)
        else $error("cursor beyond count");

    // count never exceeds the row length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("count beyond depth");

    // a refused request leaves count and cursor as they were
    a_err_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_err != ERR_OK) |=> ($stable(r_count) && $stable(r_cursor)))
        else $error("state changed on error");

    // a waiting response is never overwritten by a new request
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |-> !accept)
        else $error("response overrun");
`endif

endmodule

>>> tb/sv/csb_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the cursor buffer, predicts every response word
// and compares it with what comes out.
module csb_checker
    import csb_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    csb_req_if   req_ch,
    csb_rsp_if   rsp_ch,
    output int   o_fail_count,
    output int   o_pending
);

    // One response word as the block should return it
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               has;
        logic [POS_W-1:0]   count;
        logic [POS_W-1:0]   pos;
        logic [ERR_W-1:0]   err;
    } t_cursor_rsp_s;

    // Shadow copy of the buffer
    logic [VALUE_W-1:0] seq_mem [DEPTH];
    int unsigned        seq_len;
    int unsigned        seq_cur;

    t_cursor_rsp_s      rsp_expected_q [$];
    int                 fail_total;

    // Apply one request to the shadow buffer, return the response it causes
    function automatic t_cursor_rsp_s step_sequence(logic [REQ_W-1:0] code,
                                                    logic [VALUE_W-1:0] val);
        t_cursor_rsp_s rsp;
        logic          has_cur;
        int unsigned   i;
        rsp     = '0;
        rsp.err = ERR_OK;
        has_cur = (seq_cur < seq_len);
        case (code)
            REQ_START: begin
                seq_cur = 0;
            end
            REQ_ADVANCE: begin
                if (!has_cur) rsp.err = ERR_NO_CURRENT;
                else seq_cur++;
            end
            REQ_INSERT: begin
                if (seq_len >= DEPTH) begin
                    rsp.err = ERR_FULL;
                end else begin
                    // no current entry: the new value goes to the front
                    if (!has_cur) seq_cur = 0;
                    for (i = seq_len; i > seq_cur; i--) seq_mem[i] = seq_mem[i-1];
                    seq_mem[seq_cur] = val;
                    seq_len++;
                end
            end
            REQ_ATTACH: begin
                if (seq_len >= DEPTH) begin
                    rsp.err = ERR_FULL;
                end else if (has_cur) begin
                    for (i = seq_len; i > seq_cur + 1; i--) seq_mem[i] = seq_mem[i-1];
                    seq_mem[seq_cur+1] = val;
                    seq_cur++;
                    seq_len++;
                end else begin
                    // no current entry: the new value goes to the end
                    seq_mem[seq_len] = val;
                    seq_cur = seq_len;
                    seq_len++;
                end
            end
            REQ_REMOVE: begin
                if (!has_cur) begin
                    rsp.err = ERR_NO_CURRENT;
                end else begin
                    for (i = seq_cur + 1; i < seq_len; i++) seq_mem[i-1] = seq_mem[i];
                    seq_len--;
                end
            end
            default: begin
                // status and the spare codes leave everything as it is
            end
        endcase
        rsp.has   = (seq_cur < seq_len);
        rsp.value = rsp.has ? seq_mem[seq_cur] : '0;
        rsp.count = seq_len[POS_W-1:0];
        rsp.pos   = seq_cur[POS_W-1:0];
        return rsp;
    endfunction

    // Sample both handshakes at the clock edge
    always @(posedge i_clk) begin
        t_cursor_rsp_s want;
        t_cursor_rsp_s got;
        if (!i_rst_n) begin
            seq_len    = 0;
            seq_cur    = 0;
            fail_total = 0;
            rsp_expected_q.delete();
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.value = rsp_ch.current_value;
                got.has   = rsp_ch.has_current;
                got.count = rsp_ch.entry_count;
                got.pos   = rsp_ch.cursor_pos;
                got.err   = rsp_ch.error_code;
                if (rsp_expected_q.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("ERROR %0t: response word with no request pending", $time);
                end else begin
                    want = rsp_expected_q.pop_front();
                    if (got.value !== want.value || got.has !== want.has ||
                        got.count !== want.count || got.pos !== want.pos ||
                        got.err !== want.err) begin
                        fail_total++;
                        if (fail_total <= 10) begin
                            $write("ERROR %0t: exp/got value %h/%h has %b/%b ",
                                   $time, want.value, got.value, want.has, got.has);
                            $display("count %0d/%0d pos %0d/%0d err %0d/%0d",
                                     want.count, got.count, want.pos, got.pos,
                                     want.err, got.err);
                        end
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
                rsp_expected_q.push_back(step_sequence(req_ch.req_type, req_ch.new_value));
        end
        o_fail_count <= fail_total;
        o_pending    <= rsp_expected_q.size();
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import csb_pkg::*;

    // Spare request codes, served by the block as status
    localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

    localparam int DEPTH       = 16;
    localparam int PHASE_ITEMS = 362;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int   idle_pct;
    int   stall_pct;
    logic hold_off;
    int   fail_count;
    int   pending;

    csb_req_if req_ch ();
    csb_rsp_if rsp_ch ();

    always #10 i_clk = ~i_clk;

    cursor_sequence_buffer_top #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (VALUE_W)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    csb_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req_ch       (req_ch),
        .rsp_ch       (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Offer one request word, after a random gap, and wait until it is taken
    task automatic send_req(input logic [REQ_W-1:0] code, input logic [VALUE_W-1:0] val);
        while ($urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= code;
        req_ch.new_value <= val;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    // Response side: random stalls, plus the long hold-off
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
        end
    end

    // Long hold-off early in the stall-free phase so the block fills and backs up
    initial begin
        hold_off = 1'b0;
        wait (i_rst_n === 1'b1);
        repeat (40) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Stimulus and verdict
    initial begin
        logic [REQ_W-1:0]   code;
        logic [VALUE_W-1:0] val;
        int                 mode;
        int                 r;
        int                 drain;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = REQ_STATUS;
        req_ch.new_value = '0;
        idle_pct         = 0;
        stall_pct        = 0;
        mode             = 0;
        i_rst_n          = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty buffer, no-current cases, fill to full, spare codes
        send_req(REQ_STATUS,  32'h1234_5678);
        send_req(REQ_START,   '0);
        send_req(REQ_ADVANCE, '0);
        send_req(REQ_REMOVE,  '0);
        send_req(REQ_INSERT,  32'h0000_0000);
        send_req(REQ_ATTACH,  32'hFFFF_FFFF);
        send_req(REQ_ADVANCE, '0);
        send_req(REQ_ATTACH,  32'h5555_5555);
        send_req(REQ_ADVANCE, '0);
        send_req(REQ_INSERT,  32'hA5A5_A5A5);
        send_req(REQ_START,   '1);
        repeat (DEPTH - 4) send_req(REQ_ATTACH, $urandom);
        send_req(REQ_INSERT,  32'hDEAD_BEEF);
        send_req(REQ_ATTACH,  32'hCAFE_F00D);
        send_req(REQ_REMOVE,  '0);
        send_req(REQ_SPARE_6, '1);
        send_req(REQ_SPARE_7, '1);
        send_req(REQ_START,   '0);
        send_req(REQ_REMOVE,  '0);

        // Random: count wanders between empty and full under a changing bias
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 83; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 83; end
                default: begin idle_pct = 37; stall_pct <= 37; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 48 == 0) mode = $urandom_range(2);
                r = $urandom_range(99);
                case (mode)
                    0: begin
                        // mostly growing
                        if (r < 35)      code = REQ_INSERT;
                        else if (r < 70) code = REQ_ATTACH;
                        else if (r < 80) code = REQ_ADVANCE;
                        else if (r < 88) code = REQ_START;
                        else if (r < 95) code = REQ_REMOVE;
                        else             code = 3'($urandom_range(7, 5));
                    end
                    1: begin
                        // mostly shrinking
                        if (r < 40)      code = REQ_REMOVE;
                        else if (r < 60) code = REQ_ADVANCE;
                        else if (r < 75) code = REQ_START;
                        else if (r < 85) code = REQ_INSERT;
                        else if (r < 90) code = REQ_ATTACH;
                        else             code = 3'($urandom_range(7, 5));
                    end
                    default: code = 3'($urandom_range(7));
                endcase
                case ($urandom_range(15))
                    0:       val = '0;
                    1:       val = '1;
                    default: val = $urandom;
                endcase
                send_req(code, val);
            end
        end
        req_ch.valid <= 1'b0;

        // Drain outstanding responses, bounded
        @(posedge i_clk);
        drain = 0;
        while (pending != 0 && drain < 5000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> sim.f
hdl/csb_pkg.sv
hdl/csb_if.sv
hdl/csb_cell.sv
hdl/cursor_sequence_buffer_top.sv
tb/sv/csb_checker.sv
tb/sv/tb_top.sv
